/* design/spq_pkg.sv */
// Shared constants and types of the sorted priority queue.
package spq_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned PrioBits  = 8;
  localparam int unsigned CountBits = $clog2(Depth + 1);

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  localparam logic CmdEnqueue = 1'b0;
  localparam logic CmdDequeue = 1'b1;

  typedef struct packed {
    logic [PrioBits-1:0] prio;
    logic [DataBits-1:0] data;
  } entry_t;

  // Operation broadcast to every cell at once.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctrl_t;

endpackage

/* design/spq_if.sv */
// Handshake channels of the sorted priority queue: command in, result out.
interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [spq_pkg::DataBits-1:0]  item_data;
  logic [spq_pkg::PrioBits-1:0]  item_priority;

  modport source (output valid, command, item_data, item_priority, input ready);
  modport sink   (input valid, command, item_data, item_priority, output ready);
endinterface

interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [spq_pkg::DataBits-1:0]  out_data;
  logic [spq_pkg::PrioBits-1:0]  out_priority;
  logic [spq_pkg::CountBits-1:0] occupancy;

  modport source (output valid, status, out_data, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_data, out_priority, occupancy, output ready);
endinterface

/* design/spq_cell.sv */
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  logic                left_keep_i,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  output logic                keep_o,
  output spq_pkg::entry_t     entry_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // Stay in place on enqueue when this entry ranks at or above the new one.
  assign keep_o  = occupied_i && (entry_q.prio >= ctrl_i.item.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.deq) begin
      // advance toward the head
      entry_d = right_i;
    end else if (ctrl_i.enq && !keep_o) begin
      // first cell that does not keep takes the new item, the rest shift back
      entry_d = left_keep_i ? ctrl_i.item : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* design/sorted_priority_queue.sv */
// Sorted priority queue: top level with the cell chain and the result register.
//
// in_i carries commands: enqueue (data and priority) or dequeue. out_o carries
// one result per command: status, the removed head entry on a dequeue, and the
// occupancy after the command. Both channels transfer on valid && ready.
// Entries live in a row of Depth cells kept sorted, highest priority at the
// head; a new entry lands behind all entries of equal or higher priority.
// Every cell compares and shifts at once, so a command completes in the cycle
// it is accepted and its result is shown from the next cycle on.
// Throughput: one command per cycle while out_o drains, bounded by the single
// result register in front of out_o.
// If the receiver stalls, the result holds and in_i.ready drops until it is
// taken. An enqueue on a full queue reports full, a dequeue on an empty queue
// reports empty; neither changes the contents.
// Reset empties the queue and clears any pending result; entry storage is not
// cleared, since only slots below the count are ever read.
module sorted_priority_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned Depth = spq_pkg::Depth;
  localparam int unsigned CntW  = spq_pkg::CountBits;

  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  logic [1:0]          status_q, status_d;
  logic [spq_pkg::DataBits-1:0] data_q, data_d;
  logic [spq_pkg::PrioBits-1:0] prio_q, prio_d;

  logic                transfer_in;
  logic                is_full, is_empty;
  spq_pkg::cell_ctrl_t ctrl;

  logic            [Depth-1:0] occupied;
  logic            [Depth-1:0] keep;
  spq_pkg::entry_t [Depth-1:0] entry;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign transfer_in = in_i.valid && in_i.ready;
  assign is_full     = (count_q == CntW'(Depth));
  assign is_empty    = (count_q == '0);

  assign ctrl.enq       = transfer_in && (in_i.command == spq_pkg::CmdEnqueue) && !is_full;
  assign ctrl.deq       = transfer_in && (in_i.command == spq_pkg::CmdDequeue) && !is_empty;
  assign ctrl.item.prio = in_i.item_priority;
  assign ctrl.item.data = in_i.item_data;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            left_keep;

    assign occupied[k] = (count_q > CntW'(k));

    if (k == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left      = '0;
    end else begin : g_body
      assign left_keep = keep[k-1];
      assign left      = entry[k-1];
    end

    if (k == Depth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = entry[k+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied[k]),
      .left_keep_i (left_keep),
      .left_i      (left),
      .right_i     (right),
      .keep_o      (keep[k]),
      .entry_o     (entry[k])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::StOk;
    data_d   = '0;
    prio_d   = '0;
    if (in_i.command == spq_pkg::CmdEnqueue) begin
      if (is_full) begin
        status_d = spq_pkg::StFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = spq_pkg::StEmpty;
      end else begin
        count_d = count_q - CntW'(1);
        data_d  = entry[0].data;
        prio_d  = entry[0].prio;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (transfer_in) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (transfer_in) begin
      status_q <= status_d;
      data_q   <= data_d;
      prio_q   <= prio_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.out_data     = data_q;
  assign out_o.out_priority = prio_q;
  assign out_o.occupancy    = count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count exceeds depth");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupied[1] |-> (entry[0].prio >= entry[1].prio))
    else $error("head entry ranks below its successor");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == spq_pkg::StFull)) |-> (count_q == CntW'(Depth)))
    else $error("full status reported on a queue that is not full");

  a_deq_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.deq |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("dequeue did not lower the count by one");

endmodule

/* tb/spq_checker.sv */
`timescale 1ns / 1ps
// Result checker for the sorted priority queue: tracks the sorted contents and compares results.
module spq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_in_if           cmd_mon,
  spq_out_if          res_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned Depth     = spq_pkg::Depth;
  localparam int unsigned DataBits  = spq_pkg::DataBits;
  localparam int unsigned PrioBits  = spq_pkg::PrioBits;
  localparam int unsigned CountBits = spq_pkg::CountBits;

  typedef struct packed {
    logic [1:0]           status;
    logic [DataBits-1:0]  data;
    logic [PrioBits-1:0]  prio;
    logic [CountBits-1:0] occ;
  } queue_result_t;

  spq_pkg::entry_t slots [Depth];
  int unsigned     held;
  queue_result_t   expected_results [$];
  int unsigned     mismatches;

  // Apply one command to the tracked contents and return the result it must produce.
  function automatic queue_result_t apply_command(logic cmd, logic [DataBits-1:0] d,
                                                  logic [PrioBits-1:0] p);
    queue_result_t r;
    int unsigned   pos;
    r = '0;
    if (cmd == spq_pkg::CmdEnqueue) begin
      if (held >= Depth) begin
        r.status = spq_pkg::StFull;
      end else begin
        // Land behind every entry of equal or higher priority.
        pos = 0;
        while (pos < held && slots[pos].prio >= p) pos++;
        for (int unsigned k = held; k > pos; k--) slots[k] = slots[k-1];
        slots[pos].data = d;
        slots[pos].prio = p;
        held++;
        r.status = spq_pkg::StOk;
      end
    end else begin
      if (held == 0) begin
        r.status = spq_pkg::StEmpty;
      end else begin
        r.status = spq_pkg::StOk;
        r.data   = slots[0].data;
        r.prio   = slots[0].prio;
        for (int unsigned k = 1; k < held; k++) slots[k-1] = slots[k];
        held--;
      end
    end
    r.occ = CountBits'(held);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    queue_result_t got;
    queue_result_t want;
    if (!rst_ni) begin
      held = 0;
      mismatches = 0;
      expected_results.delete();
      pending_o      <= 0;
      mismatch_cnt_o <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got.status = res_mon.status;
        got.data   = res_mon.out_data;
        got.prio   = res_mon.out_priority;
        got.occ    = res_mon.occupancy;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result: st=%0d data=%h prio=%0d occ=%0d",
                     $realtime, got.status, got.data, got.prio, got.occ);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.data !== want.data ||
              got.prio !== want.prio || got.occ !== want.occ) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: exp st=%0d data=%h prio=%0d occ=%0d, ",
                        "got st=%0d data=%h prio=%0d occ=%0d"},
                       $realtime, want.status, want.data, want.prio, want.occ,
                       got.status, got.data, got.prio, got.occ);
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready)
        expected_results.push_back(apply_command(cmd_mon.command, cmd_mon.item_data,
                                                 cmd_mon.item_priority));
      pending_o      <= expected_results.size();
      mismatch_cnt_o <= mismatches;
    end
  end

endmodule

/* tb/sorted_priority_queue_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the sorted priority queue: clock, reset, command stimulus and verdict.
module sorted_priority_queue_tb;

  localparam int unsigned RandomItems = 1300;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DataBits    = spq_pkg::DataBits;
  localparam int unsigned PrioBits    = spq_pkg::PrioBits;

  logic clk_i;
  logic rst_ni;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  int unsigned mismatches;
  int unsigned pending;

  sorted_priority_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  spq_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_mon        (in_ch),
    .res_mon        (out_ch),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  int unsigned burst_left;
  int unsigned gap_max;

  // Offer one command and hold it until the transfer; open a new burst after a random gap when gap_max is nonzero.
  task automatic send_cmd(logic cmd, logic [DataBits-1:0] d, logic [PrioBits-1:0] p);
    int unsigned n;
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        n = $urandom_range(1, gap_max);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.item_data     <= d;
    in_ch.item_priority <= p;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stop offering until every outstanding result has been taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [PrioBits-1:0] pick_prio(int unsigned mode);
    case (mode)
      0:       return PrioBits'($urandom());
      1:       return PrioBits'($urandom_range(0, 3));
      2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return PrioBits'(126 + $urandom_range(0, 4));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned issued;
    int unsigned phase_left;
    int unsigned enq_pct;
    int unsigned prio_mode;
    bit          paused;
    logic        cmd;
    in_ch.valid         = 1'b0;
    in_ch.command       = spq_pkg::CmdEnqueue;
    in_ch.item_data     = '0;
    in_ch.item_priority = '0;
    rst_ni     = 1'b0;
    burst_left = 0;
    gap_max    = 3;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dequeue on empty, extremes, equal priorities, fill and refuse.
    send_cmd(spq_pkg::CmdDequeue, '1, '1);
    send_cmd(spq_pkg::CmdEnqueue, '0, '0);
    send_cmd(spq_pkg::CmdEnqueue, '1, '1);
    for (int i = 0; i < 3; i++)
      send_cmd(spq_pkg::CmdEnqueue, DataBits'(32'h1000 + i), PrioBits'(128));
    send_cmd(spq_pkg::CmdDequeue, '0, '0);
    send_cmd(spq_pkg::CmdDequeue, '0, '0);
    for (int i = 0; i < 13; i++)
      send_cmd(spq_pkg::CmdEnqueue, DataBits'($urandom()), PrioBits'($urandom()));
    send_cmd(spq_pkg::CmdEnqueue, '1, '1);
    send_cmd(spq_pkg::CmdEnqueue, '0, '0);
    send_cmd(spq_pkg::CmdDequeue, '1, '1);
    send_cmd(spq_pkg::CmdDequeue, '0, '0);
    wait_drained();

    // Random: phases that push the level toward full, toward empty, or keep it wandering.
    issued     = 0;
    phase_left = 0;
    paused     = 1'b0;
    enq_pct    = 50;
    prio_mode  = 0;
    while (issued < RandomItems) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 60);
        case ($urandom_range(0, 2))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          default: enq_pct = 85;
        endcase
        prio_mode = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
          0:       gap_max = 0;
          1:       gap_max = 2;
          2:       gap_max = 6;
          default: gap_max = 12;
        endcase
      end
      phase_left--;
      if (!paused && issued >= RandomItems / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      cmd = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::CmdEnqueue : spq_pkg::CmdDequeue;
      send_cmd(cmd, DataBits'($urandom()), pick_prio(prio_mode));
      issued++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: stall patterns per segment, plus one long hold-off that back-pressures the command side.
  initial begin : result_sink
    int unsigned seg_left;
    int unsigned mode;
    int unsigned taken;
    bit          hold_done;
    out_ch.ready = 1'b0;
    seg_left  = 0;
    mode      = 0;
    taken     = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) taken++;
      if (!hold_done && taken >= 500) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 150);
      end
      seg_left--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 2) == 0);
        default: out_ch.ready <= seg_left[2];
      endcase
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule
